@@ rtl/core/btmx_pkg.sv @@
`timescale 1ns / 1ps

package btmx_pkg;

	typedef logic [1:0] func_t;
	typedef logic [1:0] status_t;

	localparam func_t FUNC_INSERT = 2'd0;
	localparam func_t FUNC_QUERY  = 2'd1;
	localparam func_t FUNC_CLEAR  = 2'd2;

	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_FULL  = 2'd1;
	localparam status_t STATUS_EMPTY = 2'd2;

endpackage

@@ rtl/core/btmx_ram.sv @@
`timescale 1ns / 1ps

module btmx_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/binary_trie_max_xor.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             func, key
// result    out        done (one cycle, no stall) xor_max, running_max, status
//
// Clear, unused codes and a query on an empty store answer in the cycle after accept.
// Query: walks one trie level per step, root links from flops and the others from node memory reads.
// Insert: walk until the path ends, then write the new nodes one by one in ST_ALLOC; a key that is
// already stored answers at the end of the walk without writing.
// Reset (arst_n low) empties the trie; the node memory needs no clearing pass since
// nodes are written when allocated. The receiver cannot stall: done lasts one cycle.

module binary_trie_max_xor #(
	parameter int KEY_BITS   = 32,
	parameter int POOL_NODES = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  btmx_pkg::func_t         func,
	input  logic [31:0]             key,
	output logic                    done,
	output logic [31:0]             xor_max,
	output logic [31:0]             running_max,
	output btmx_pkg::status_t       status
);

	localparam int LW  = $clog2(POOL_NODES + 1);   // link: index + 1, 0 = null
	localparam int AW  = $clog2(POOL_NODES);
	localparam int LVW = $clog2(KEY_BITS);
	localparam int SW  = LW + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_ALLOC} state_t;

	state_t                  state_q;
	btmx_pkg::func_t         func_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [LVW-1:0]          lvl_q;
	logic [LW-1:0]           h_q;
	logic [KEY_BITS-1:0]     acc_q;
	logic [LW-1:0]           root0_q, root1_q;
	logic [LW-1:0]           used_q;
	logic [31:0]             best_q;

	logic                    we;
	logic [AW-1:0]           waddr, raddr;
	logic [2*LW-1:0]         wdata, rdata;

	logic [KEY_BITS-1:0]     key_w;
	logic [2*LW-1:0]         links_cur, links_upd, alloc_data;
	logic                    bit_b, acc_bit, lvl_zero, pool_full;
	logic [LW-1:0]           link_same, link_opp, nh, nh_m1, h_m1, new_link, next_link;
	logic [LVW-1:0]          lvl_m1;
	logic [KEY_BITS-1:0]     acc_next;
	logic [31:0]             xr32;
	logic [SW-1:0]           need_sum;

	btmx_ram #(
		.WIDTH(2 * LW),
		.DEPTH(POOL_NODES)
	) u_nodes (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		key_w = '0;
		for (int i = 0; i < KEY_BITS; i++) begin
			if (i < 32) begin
				key_w[i] = key[i];
			end
		end
	end

	// Root links live in flops; every other level comes from the node memory.
	assign links_cur = (h_q == '0) ? {root1_q, root0_q} : rdata;
	assign bit_b     = key_q[lvl_q];
	assign link_same = bit_b ? links_cur[2*LW-1:LW] : links_cur[LW-1:0];
	assign link_opp  = bit_b ? links_cur[LW-1:0] : links_cur[2*LW-1:LW];
	assign lvl_zero  = (lvl_q == '0);
	assign lvl_m1    = lvl_q - LVW'(1);
	assign acc_bit   = (func_q == btmx_pkg::FUNC_QUERY) && (link_opp != '0);
	assign nh        = acc_bit ? link_opp : link_same;
	assign nh_m1     = nh - LW'(1);
	assign h_m1      = h_q - LW'(1);
	assign new_link  = used_q + LW'(1);
	assign next_link = used_q + LW'(2);
	assign raddr     = nh_m1[AW-1:0];
	assign need_sum  = {1'b0, used_q} + SW'(lvl_q) + SW'(1);
	assign pool_full = need_sum > SW'(POOL_NODES);

	always_comb begin
		acc_next        = acc_q;
		acc_next[lvl_q] = acc_bit;
		xr32 = '0;
		for (int i = 0; i < 32; i++) begin
			if (i < KEY_BITS) begin
				xr32[i] = acc_next[i];
			end
		end
	end

	always_comb begin
		links_upd = links_cur;
		if (bit_b) begin
			links_upd[2*LW-1:LW] = new_link;
		end else begin
			links_upd[LW-1:0] = new_link;
		end
	end

	// New node on the inserted path: one child toward the next new node, leaf has none.
	always_comb begin
		alloc_data = '0;
		if (!lvl_zero) begin
			if (key_q[lvl_m1]) begin
				alloc_data[2*LW-1:LW] = next_link;
			end else begin
				alloc_data[LW-1:0] = next_link;
			end
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = h_m1[AW-1:0];
		wdata = links_upd;
		unique case (state_q)
			ST_WALK: begin
				if (func_q == btmx_pkg::FUNC_INSERT && link_same == '0 && !pool_full
						&& h_q != '0) begin
					we = 1'b1;
				end
			end
			ST_ALLOC: begin
				we    = 1'b1;
				waddr = used_q[AW-1:0];
				wdata = alloc_data;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			func_q      <= btmx_pkg::FUNC_INSERT;
			key_q       <= '0;
			lvl_q       <= '0;
			h_q         <= '0;
			acc_q       <= '0;
			root0_q     <= '0;
			root1_q     <= '0;
			used_q      <= '0;
			best_q      <= '0;
			done        <= 1'b0;
			xor_max     <= '0;
			running_max <= '0;
			status      <= btmx_pkg::STATUS_OK;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						func_q <= func;
						key_q  <= key_w;
						lvl_q  <= LVW'(KEY_BITS - 1);
						h_q    <= '0;
						acc_q  <= '0;
						unique case (func)
							btmx_pkg::FUNC_INSERT: begin
								state_q <= ST_WALK;
							end
							btmx_pkg::FUNC_QUERY: begin
								if (root0_q == '0 && root1_q == '0) begin
									done        <= 1'b1;
									xor_max     <= '0;
									running_max <= best_q;
									status      <= btmx_pkg::STATUS_EMPTY;
								end else begin
									state_q <= ST_WALK;
								end
							end
							btmx_pkg::FUNC_CLEAR: begin
								root0_q     <= '0;
								root1_q     <= '0;
								used_q      <= '0;
								best_q      <= '0;
								done        <= 1'b1;
								xor_max     <= '0;
								running_max <= '0;
								status      <= btmx_pkg::STATUS_OK;
							end
							default: begin
								done        <= 1'b1;
								xor_max     <= '0;
								running_max <= best_q;
								status      <= btmx_pkg::STATUS_OK;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (func_q == btmx_pkg::FUNC_QUERY) begin
						acc_q <= acc_next;
						h_q   <= nh;
						lvl_q <= lvl_m1;
						if (lvl_zero) begin
							state_q     <= ST_IDLE;
							done        <= 1'b1;
							xor_max     <= xr32;
							running_max <= (xr32 > best_q) ? xr32 : best_q;
							best_q      <= (xr32 > best_q) ? xr32 : best_q;
							status      <= btmx_pkg::STATUS_OK;
						end
					end else if (link_same == '0) begin
						// path ends here: lvl_q + 1 new nodes needed
						if (pool_full) begin
							state_q     <= ST_IDLE;
							done        <= 1'b1;
							xor_max     <= '0;
							running_max <= best_q;
							status      <= btmx_pkg::STATUS_FULL;
						end else begin
							state_q <= ST_ALLOC;
							if (h_q == '0) begin
								root0_q <= links_upd[LW-1:0];
								root1_q <= links_upd[2*LW-1:LW];
							end
						end
					end else begin
						h_q   <= link_same;
						lvl_q <= lvl_m1;
						if (lvl_zero) begin
							// key already stored
							state_q     <= ST_IDLE;
							done        <= 1'b1;
							xor_max     <= '0;
							running_max <= best_q;
							status      <= btmx_pkg::STATUS_OK;
						end
					end
				end
				ST_ALLOC: begin
					used_q <= new_link;
					lvl_q  <= lvl_m1;
					if (lvl_zero) begin
						state_q     <= ST_IDLE;
						done        <= 1'b1;
						xor_max     <= '0;
						running_max <= best_q;
						status      <= btmx_pkg::STATUS_OK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/btmx_chk.sv @@
`timescale 1ns / 1ps

module btmx_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input btmx_pkg::func_t      func,
	input logic                 done,
	input logic [31:0]          xor_max,
	input logic [31:0]          running_max,
	input btmx_pkg::status_t    status
);

	// a word is never answered while the block is busy
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");

	// an accepted word either answers at once or keeps the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted word lost");

	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == btmx_pkg::FUNC_CLEAR) |=>
		(done && xor_max == '0 && running_max == '0 && status == btmx_pkg::STATUS_OK))
		else $error("clear did not answer zeros");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != btmx_pkg::STATUS_OK) |-> (xor_max == '0))
		else $error("nonzero result on failed word");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == btmx_pkg::STATUS_OK && xor_max != '0) |->
		(running_max >= xor_max))
		else $error("running max below query result");

endmodule

bind binary_trie_max_xor btmx_chk u_btmx_chk (.*);

@@ bench/btmx_checker.sv @@
`timescale 1ns / 1ps

module btmx_checker #(
	parameter int KEY_BITS   = 32,
	parameter int POOL_NODES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  btmx_pkg::func_t   func,
	input  logic [31:0]       key,
	input  logic              done,
	input  logic [31:0]       xor_max,
	input  logic [31:0]       running_max,
	input  btmx_pkg::status_t status,
	output int                mismatches,
	output int                answers_pending
);
	import btmx_pkg::*;

	typedef struct packed {
		logic [31:0] xr;
		logic [31:0] best;
		status_t     st;
	} answer_t;

	answer_t     answers_due[$];
	int unsigned child_link[POOL_NODES][2];
	int unsigned root_link[2];
	int unsigned nodes_taken;
	logic [31:0] best_xor;

	// handle 0 is the root, handle h > 0 is pool node h - 1; link 0 means null
	function automatic int unsigned link_at(int unsigned h, bit b);
		if (h == 0) begin
			return root_link[b];
		end
		return child_link[h - 1][b];
	endfunction

	function automatic void link_set(int unsigned h, bit b, int unsigned v);
		if (h == 0) begin
			root_link[b] = v;
		end else begin
			child_link[h - 1][b] = v;
		end
	endfunction

	function automatic void trie_clear();
		root_link[0] = 0;
		root_link[1] = 0;
		nodes_taken  = 0;
		best_xor     = '0;
	endfunction

	function automatic status_t trie_insert(logic [63:0] k);
		int unsigned h;
		int unsigned nx;
		int unsigned missing;
		int          i;
		h       = 0;
		missing = 0;
		for (i = KEY_BITS - 1; i >= 0; i--) begin
			nx = link_at(h, k[i]);
			if (nx == 0) begin
				missing = i + 1;
				break;
			end
			h = nx;
		end
		// all or nothing: a path that does not fit leaves the trie untouched
		if (missing > POOL_NODES - nodes_taken) begin
			return STATUS_FULL;
		end
		h = 0;
		for (i = KEY_BITS - 1; i >= 0; i--) begin
			nx = link_at(h, k[i]);
			if (nx == 0) begin
				child_link[nodes_taken][0] = 0;
				child_link[nodes_taken][1] = 0;
				nodes_taken++;
				nx = nodes_taken;
				link_set(h, k[i], nx);
			end
			h = nx;
		end
		return STATUS_OK;
	endfunction

	function automatic logic [31:0] trie_max_xor(logic [63:0] k);
		int unsigned h;
		int unsigned opp;
		logic [63:0] r;
		int          i;
		h = 0;
		r = '0;
		for (i = KEY_BITS - 1; i >= 0; i--) begin
			opp = link_at(h, !k[i]);
			if (opp != 0) begin
				r[i] = 1'b1;
				h    = opp;
			end else begin
				h = link_at(h, k[i]);
			end
		end
		return r[31:0];
	endfunction

	function automatic answer_t predict_answer(func_t f, logic [31:0] k);
		answer_t a;
		a = '{xr: '0, best: '0, st: STATUS_OK};
		case (f)
			FUNC_INSERT: begin
				a.st = trie_insert({32'd0, k});
			end
			FUNC_QUERY: begin
				if (root_link[0] == 0 && root_link[1] == 0) begin
					a.st = STATUS_EMPTY;
				end else begin
					a.xr = trie_max_xor({32'd0, k});
					if (a.xr > best_xor) begin
						best_xor = a.xr;
					end
				end
			end
			FUNC_CLEAR: begin
				trie_clear();
			end
			default: begin
				// unused code: no effect
			end
		endcase
		a.best = best_xor;
		return a;
	endfunction

	function automatic void flag(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		$display("%0t: %s expected %h got %h", $time, what, want, got);
	endfunction

	initial begin
		mismatches      = 0;
		answers_pending = 0;
		trie_clear();
	end

	always @(posedge clk) begin
		answer_t want;
		if (!arst_n) begin
			trie_clear();
			answers_due.delete();
		end else begin
			if (done) begin
				if (answers_due.size() == 0) begin
					mismatches++;
					$display("%0t: result word expected none got %h %h %h",
						$time, xor_max, running_max, status);
				end else begin
					want = answers_due.pop_front();
					if (xor_max !== want.xr) begin
						flag("xor_max", want.xr, xor_max);
					end
					if (running_max !== want.best) begin
						flag("running_max", want.best, running_max);
					end
					if (status !== want.st) begin
						flag("status", 32'(want.st), 32'(status));
					end
				end
			end
			if (start && !busy) begin
				answers_due.push_back(predict_answer(func, key));
			end
		end
		answers_pending = answers_due.size();
	end

endmodule

@@ bench/binary_trie_max_xor_tb.sv @@
`timescale 1ns / 1ps

module binary_trie_max_xor_tb;
	import btmx_pkg::*;

	localparam func_t FUNC_UNUSED = 2'd3;

	localparam int EP_FILL    = 0;
	localparam int EP_CLUSTER = 1;
	localparam int EP_WIDE    = 2;

	localparam int RANDOM_WORDS = 1500;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	func_t       func;
	logic [31:0] key;
	logic        done;
	logic [31:0] xor_max;
	logic [31:0] running_max;
	status_t     status;

	int          mismatch_count;
	int          words_in_flight;
	bit          steady;
	int unsigned words_sent;
	logic [31:0] kept_keys[$];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	binary_trie_max_xor uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.key         (key),
		.done        (done),
		.xor_max     (xor_max),
		.running_max (running_max),
		.status      (status)
	);

	btmx_checker answer_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.key             (key),
		.done            (done),
		.xor_max         (xor_max),
		.running_max     (running_max),
		.status          (status),
		.mismatches      (mismatch_count),
		.answers_pending (words_in_flight)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// mostly keys near base (bits under mask vary), with the odd corner key
	function automatic logic [31:0] make_key(logic [31:0] base, logic [31:0] mask);
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'd1 << $urandom_range(0, 31);
			3: return ~(32'd1 << $urandom_range(0, 31));
			default: return (base & ~mask) | ($urandom & mask);
		endcase
	endfunction

	task automatic push_word(func_t f, logic [31:0] k);
		int gap;
		start <= 1'b1;
		func  <= f;
		key   <= k;
		do @(posedge clk); while (busy);
		if (f != FUNC_UNUSED) begin
			words_sent++;
		end
		if (f == FUNC_INSERT) begin
			kept_keys.push_back(k);
		end
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			func  <= func_t'($urandom);
			key   <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic run_episode(int kind);
		int          n;
		int          i;
		int          pick;
		logic [31:0] base;
		logic [31:0] mask;
		kept_keys.delete();
		steady = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 4) != 0) begin
			push_word(FUNC_CLEAR, $urandom);
		end
		base = $urandom;
		mask = (kind == EP_CLUSTER) ? 32'hFFFF_FFFF >> $urandom_range(20, 31) : 32'hFFFF_FFFF;
		if (kind == EP_FILL) begin
			// enough random keys to run the pool dry, then poke at the full pool
			n = $urandom_range(180, 230);
			for (i = 0; i < n; i++) begin
				push_word(($urandom_range(0, 4) == 0) ? FUNC_QUERY : FUNC_INSERT, $urandom);
			end
			for (i = 0; i < 25; i++) begin
				pick = $urandom_range(0, 2);
				if (pick == 0 && kept_keys.size() > 0) begin
					push_word(FUNC_INSERT, kept_keys[$urandom_range(0, kept_keys.size() - 1)]);
				end else if (pick == 1) begin
					push_word(FUNC_INSERT, $urandom);
				end else begin
					push_word(FUNC_QUERY, $urandom);
				end
			end
		end else begin
			n = $urandom_range(10, 60);
			for (i = 0; i < n; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					push_word(FUNC_INSERT, make_key(base, mask));
				end else if (pick < 90) begin
					push_word(FUNC_QUERY, ($urandom_range(0, 9) < 7) ? make_key(base, mask)
						: $urandom);
				end else if (pick < 95) begin
					push_word(FUNC_UNUSED, $urandom);
				end else begin
					push_word(FUNC_CLEAR, $urandom);
				end
			end
		end
	endtask

	initial begin
		int ep;
		arst_n     = 1'b0;
		start      = 1'b0;
		func       = FUNC_INSERT;
		key        = '0;
		steady     = 1'b0;
		words_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		push_word(FUNC_QUERY,  32'h0000_0000);	// empty store
		push_word(FUNC_UNUSED, 32'hFFFF_FFFF);
		push_word(FUNC_INSERT, 32'h0000_0000);
		push_word(FUNC_QUERY,  32'h0000_0000);
		push_word(FUNC_QUERY,  32'hFFFF_FFFF);
		push_word(FUNC_INSERT, 32'hFFFF_FFFF);
		push_word(FUNC_QUERY,  32'h0000_0000);
		push_word(FUNC_QUERY,  32'h8000_0000);
		push_word(FUNC_INSERT, 32'h0000_0000);	// already stored
		push_word(FUNC_INSERT, 32'h8000_0000);
		push_word(FUNC_QUERY,  32'h7FFF_FFFF);
		push_word(FUNC_UNUSED, 32'h0000_0000);	// running max must hold
		push_word(FUNC_CLEAR,  32'hA5A5_5A5A);
		push_word(FUNC_QUERY,  32'h1234_5678);	// empty again after clear
		push_word(FUNC_INSERT, 32'h5555_5555);
		push_word(FUNC_INSERT, 32'hAAAA_AAAA);
		push_word(FUNC_QUERY,  32'h5555_5555);
		push_word(FUNC_QUERY,  32'hAAAA_AAAA);
		push_word(FUNC_INSERT, 32'h0000_0001);
		push_word(FUNC_QUERY,  32'h0000_0001);
		push_word(FUNC_CLEAR,  32'h0000_0000);
		push_word(FUNC_UNUSED, 32'h8000_0001);

		words_sent = 0;
		ep         = 0;
		while (words_sent < RANDOM_WORDS) begin
			if (ep % 6 == 0) begin
				run_episode(EP_FILL);
			end else begin
				run_episode(($urandom_range(0, 1) == 0) ? EP_CLUSTER : EP_WIDE);
			end
			ep++;
		end
		start <= 1'b0;

		@(posedge clk);
		while (words_in_flight != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && words_in_flight == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
